// ===== hw/rtl/psm_pkg.sv =====
package psm_pkg;

	// Stack cells and instruction fields
	localparam int DATA_W      = 32;
	localparam int PC_W        = 16;
	localparam int ARG_W       = 16;
	localparam int STACK_DEPTH = 512;
	// Static links followed at most, whatever the level field asks
	localparam int MAX_LEVEL   = 3;

	// Instruction opcodes
	typedef enum logic [3:0] {
		FN_NOP = 4'd0,
		FN_LIT = 4'd1,
		FN_OPR = 4'd2,
		FN_LOD = 4'd3,
		FN_STO = 4'd4,
		FN_CAL = 4'd5,
		FN_INC = 4'd6,
		FN_JMP = 4'd7,
		FN_JPC = 4'd8,
		FN_WRT = 4'd9,
		FN_STP = 4'd10,
		FN_LID = 4'd11,
		FN_LDA = 4'd12,
		FN_SID = 4'd13
	} func_t;

	// Operator codes carried in the argument of opr
	typedef enum logic [3:0] {
		OPR_RET = 4'd0,
		OPR_NEG = 4'd1,
		OPR_ADD = 4'd2,
		OPR_SUB = 4'd3,
		OPR_MUL = 4'd4,
		OPR_DIV = 4'd5,
		OPR_ODD = 4'd6,
		OPR_MOD = 4'd7,
		OPR_EQ  = 4'd8,
		OPR_NE  = 4'd9,
		OPR_LT  = 4'd10,
		OPR_LE  = 4'd11,
		OPR_GT  = 4'd12,
		OPR_GE  = 4'd13
	} opr_t;

	// Result status codes
	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_RANGE    = 2'd1,
		STS_DIV_ZERO = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_WALK_DATA,
		S_DECODE,
		S_RD1,
		S_RD1_DATA,
		S_RD2,
		S_RD2_DATA,
		S_ALU,
		S_ALU_WAIT,
		S_WRITE,
		S_DONE
	} psm_state_t;

	typedef struct packed {
		logic [3:0]       func;
		logic [1:0]       level_diff;
		logic [ARG_W-1:0] argument;
	} psm_in_t;

	typedef struct packed {
		logic [PC_W-1:0]          next_pc;
		logic                     write_valid;
		logic signed [DATA_W-1:0] write_value;
		logic                     halted;
		logic [1:0]               status;
	} psm_out_t;

	typedef struct packed {
		logic              start;
		opr_t              op;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic              div_zero;
		logic [DATA_W-1:0] value;
	} alu_rsp_t;

endpackage

// ===== hw/rtl/psm_alu.sv =====
module psm_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  psm_pkg::alu_req_t req,
	output psm_pkg::alu_rsp_t rsp
);
	import psm_pkg::*;

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic              qneg_q;
	logic              rneg_q;
	logic              mod_q;
	logic              dz_q;
	logic [DATA_W-1:0] value_q;

	logic              is_div;
	logic [DATA_W-1:0] simple;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] x_mag;
	logic [DATA_W-1:0] y_mag;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] q_fix;
	logic [DATA_W-1:0] r_fix;

	assign is_div = (req.op == OPR_DIV) || (req.op == OPR_MOD);
	assign prod   = req.x * req.y;
	assign x_mag  = req.x[DATA_W-1] ? (DATA_W'(0) - req.x) : req.x;
	assign y_mag  = req.y[DATA_W-1] ? (DATA_W'(0) - req.y) : req.y;

	// Operators other than div and mod
	always_comb begin
		case (req.op)
			OPR_NEG: simple = DATA_W'(0) - req.x;
			OPR_ODD: simple = req.x[0] ? (req.x[DATA_W-1] ? '1 : DATA_W'(1)) : '0;
			OPR_ADD: simple = req.x + req.y;
			OPR_SUB: simple = req.x - req.y;
			OPR_MUL: simple = prod;
			OPR_EQ:  simple = DATA_W'(req.x == req.y);
			OPR_NE:  simple = DATA_W'(req.x != req.y);
			OPR_LT:  simple = DATA_W'($signed(req.x) <  $signed(req.y));
			OPR_LE:  simple = DATA_W'($signed(req.x) <= $signed(req.y));
			OPR_GT:  simple = DATA_W'($signed(req.x) >  $signed(req.y));
			OPR_GE:  simple = DATA_W'($signed(req.x) >= $signed(req.y));
			default: simple = '0;
		endcase
	end

	// Restoring divide step, one quotient bit per cycle
	assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign q_fix  = qneg_q ? (DATA_W'(0) - quo_q) : quo_q;
	assign r_fix  = rneg_q ? (DATA_W'(0) - rem_q[DATA_W-1:0]) : rem_q[DATA_W-1:0];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (is_div && (req.y != '0)) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DATA_W);
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			value_q <= simple;
			dz_q    <= 1'b0;
			if (is_div) begin
				if (req.y == '0) begin
					value_q <= '0;
					dz_q    <= 1'b1;
				end else begin
					rem_q  <= '0;
					quo_q  <= x_mag;
					den_q  <= y_mag;
					qneg_q <= req.x[DATA_W-1] ^ req.y[DATA_W-1];
					rneg_q <= req.x[DATA_W-1];
					mod_q  <= (req.op == OPR_MOD);
				end
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (!diff[DATA_W]) begin
					rem_q <= diff;
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end else begin
				value_q <= mod_q ? r_fix : q_fix;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign rsp.value    = value_q;

endmodule

// ===== hw/rtl/pcode_stack_machine_executor_top.sv =====
// P-code stack machine executor. Each transfer on instr is one instruction
// (opcode, level difference, argument); each transfer on result gives the pc
// to fetch next, a value emitted by wrt, halt when that pc is zero, and a
// status (stack index out of range, or divide/modulo by zero). After reset the
// block clears its data stack one cell per cycle, so instr_ready stays low until
// every cell is cleared. An instruction is then accepted, walks its static links
// if it is lod, sto, cal, lid, lda or sid, is decoded and range checked, does
// its stack reads, its operator and its stack writes, and finishes; div and mod
// run in the shared bit-serial divider. All work goes through one single-port-read,
// single-port-write stack RAM and one shared ALU, so one instruction is in flight
// at a time. The result sits in an output register, so the next instruction is
// taken while it waits.
module pcode_stack_machine_executor_top #(
	parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instr_valid,
	output logic              instr_ready,
	input  psm_pkg::psm_in_t  instr,
	output logic              result_valid,
	input  logic              result_ready,
	output psm_pkg::psm_out_t result
);
	import psm_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int XW = DATA_W + 3;
	localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);

	function automatic logic inr(input logic signed [XW-1:0] v);
		inr = !v[XW-1] && (v < DEPTH_X);
	endfunction

	function automatic logic signed [XW-1:0] sx(input logic [DATA_W-1:0] v);
		sx = $signed({{(XW-DATA_W){v[DATA_W-1]}}, v});
	endfunction

	function automatic logic signed [XW-1:0] ux(input logic [AW-1:0] v);
		ux = $signed({{(XW-AW){1'b0}}, v});
	endfunction

	// Architectural and sequencer registers
	psm_state_t        state_q, state_d;
	logic [AW-1:0]     t_q, t_d;
	logic [AW-1:0]     b_q, b_d;
	logic [PC_W-1:0]   pc_q, pc_d;
	logic [AW-1:0]     clr_q, clr_d;
	logic              rv_q, rv_d;
	psm_out_t          res_q, res_d;

	logic [3:0]        func_q, func_d;
	logic [ARG_W-1:0]  arg_q, arg_d;
	logic [1:0]        cnt_q, cnt_d;
	logic [DATA_W-1:0] cur_q, cur_d;
	logic [AW-1:0]     ra_q, ra_d;
	logic [AW-1:0]     wa_q, wa_d;
	logic [DATA_W-1:0] wd_q, wd_d;
	logic [1:0]        wcnt_q, wcnt_d;
	logic [DATA_W-1:0] opa_q, opa_d;
	logic [DATA_W-1:0] opb_q, opb_d;
	logic [AW-1:0]     tn_q, tn_d;
	logic [AW-1:0]     bn_q, bn_d;
	logic [PC_W-1:0]   np_q, np_d;
	logic              fault_q, fault_d;
	logic              dz_q, dz_d;
	logic              wv_q, wv_d;
	logic [DATA_W-1:0] wval_q, wval_d;

	// Stack RAM
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [DATA_W-1:0] mem_wd;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	// Address arithmetic
	logic signed [XW-1:0] tx, bx, ax, wx, ea, dx;
	logic signed [XW-1:0] t_p1, t_p3, t_pa;
	logic [1:0]           lev_eff;
	logic                 walk_op;
	logic                 opr_ok;
	logic                 opr_bin;
	logic [PC_W-1:0]      pc_fin;

	assign tx   = ux(t_q);
	assign bx   = ux(b_q);
	assign ax   = $signed({{(XW-ARG_W){1'b0}}, arg_q});
	assign wx   = sx(cur_q);
	assign ea   = wx + ax;
	assign dx   = sx(rd_data_q);
	assign t_p1 = tx + XW'(1);
	assign t_p3 = tx + XW'(3);
	assign t_pa = tx + ax;

	assign lev_eff = (int'(instr.level_diff) > MAX_LEVEL) ? 2'(MAX_LEVEL) : instr.level_diff;
	assign walk_op = instr.func inside {FN_LOD, FN_STO, FN_CAL, FN_LID, FN_LDA, FN_SID};
	assign opr_ok  = (arg_q[ARG_W-1:4] == '0) && (arg_q[3:0] <= OPR_GE);
	assign opr_bin = arg_q[3:0] inside {[OPR_ADD:OPR_DIV], [OPR_MOD:OPR_GE]};
	assign pc_fin  = fault_q ? (pc_q + PC_W'(1)) : np_q;

	assign instr_ready  = (state_q == S_IDLE);
	assign result_valid = rv_q;
	assign result       = res_q;

	psm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data_q <= mem[mem_ra];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			t_q     <= '0;
			b_q     <= AW'(1);
			pc_q    <= '0;
			clr_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			t_q     <= t_d;
			b_q     <= b_d;
			pc_q    <= pc_d;
			clr_q   <= clr_d;
			rv_q    <= rv_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		res_q   <= res_d;
		func_q  <= func_d;
		arg_q   <= arg_d;
		cnt_q   <= cnt_d;
		cur_q   <= cur_d;
		ra_q    <= ra_d;
		wa_q    <= wa_d;
		wd_q    <= wd_d;
		wcnt_q  <= wcnt_d;
		opa_q   <= opa_d;
		opb_q   <= opb_d;
		tn_q    <= tn_d;
		bn_q    <= bn_d;
		np_q    <= np_d;
		fault_q <= fault_d;
		dz_q    <= dz_d;
		wv_q    <= wv_d;
		wval_q  <= wval_d;
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		t_d     = t_q;
		b_d     = b_q;
		pc_d    = pc_q;
		clr_d   = clr_q;
		rv_d    = rv_q && !result_ready;
		res_d   = res_q;
		func_d  = func_q;
		arg_d   = arg_q;
		cnt_d   = cnt_q;
		cur_d   = cur_q;
		ra_d    = ra_q;
		wa_d    = wa_q;
		wd_d    = wd_q;
		wcnt_d  = wcnt_q;
		opa_d   = opa_q;
		opb_d   = opb_q;
		tn_d    = tn_q;
		bn_d    = bn_q;
		np_d    = np_q;
		fault_d = fault_q;
		dz_d    = dz_q;
		wv_d    = wv_q;
		wval_d  = wval_q;

		mem_we  = 1'b0;
		mem_wa  = wa_q;
		mem_wd  = wd_q;
		mem_re  = 1'b0;
		mem_ra  = ra_q;

		alu_req.start = 1'b0;
		alu_req.op    = opr_t'(arg_q[3:0]);
		alu_req.x     = opa_q;
		alu_req.y     = opb_q;

		case (state_q)
			// Zero the stack after reset
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				clr_d  = clr_q + AW'(1);
				if (clr_q == LAST_IDX) state_d = S_IDLE;
			end

			S_IDLE: begin
				if (instr_valid) begin
					func_d  = instr.func;
					arg_d   = instr.argument;
					cnt_d   = lev_eff;
					cur_d   = {{(DATA_W-AW){1'b0}}, b_q};
					fault_d = 1'b0;
					dz_d    = 1'b0;
					wv_d    = 1'b0;
					wval_d  = '0;
					tn_d    = t_q;
					bn_d    = b_q;
					np_d    = pc_q + PC_W'(1);
					wcnt_d  = '0;
					state_d = walk_op ? S_WALK : S_DECODE;
				end
			end

			// Follow static links
			S_WALK: begin
				if (cnt_q == '0) begin
					state_d = S_DECODE;
				end else if (!inr(wx)) begin
					fault_d = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re  = 1'b1;
					mem_ra  = cur_q[AW-1:0];
					state_d = S_WALK_DATA;
				end
			end

			S_WALK_DATA: begin
				cur_d   = rd_data_q;
				cnt_d   = cnt_q - 2'd1;
				state_d = S_WALK;
			end

			// Range checks and first access per opcode
			S_DECODE: begin
				state_d = S_DONE;
				case (func_q)
					FN_LIT: begin
						if (!inr(t_p1)) fault_d = 1'b1;
						else begin
							wa_d    = t_p1[AW-1:0];
							wd_d    = {{(DATA_W-ARG_W){1'b0}}, arg_q};
							tn_d    = t_p1[AW-1:0];
							state_d = S_WRITE;
						end
					end
					FN_OPR: begin
						if (opr_ok) begin
							if (arg_q[3:0] == OPR_RET) begin
								if ((b_q == '0) || !inr(bx + XW'(2))) fault_d = 1'b1;
								else begin
									ra_d    = b_q + AW'(1);
									state_d = S_RD1;
								end
							end else if ((arg_q[3:0] == OPR_NEG) || (arg_q[3:0] == OPR_ODD)) begin
								ra_d    = t_q;
								state_d = S_RD1;
							end else if (opr_bin) begin
								if (t_q == '0) fault_d = 1'b1;
								else begin
									ra_d    = t_q - AW'(1);
									state_d = S_RD1;
								end
							end
						end
					end
					FN_LOD: begin
						if (!inr(ea) || !inr(t_p1)) fault_d = 1'b1;
						else begin
							ra_d    = ea[AW-1:0];
							state_d = S_RD1;
						end
					end
					FN_STO: begin
						if (!inr(ea) || (t_q == '0)) fault_d = 1'b1;
						else begin
							wa_d    = ea[AW-1:0];
							ra_d    = t_q;
							state_d = S_RD1;
						end
					end
					FN_CAL: begin
						if (!inr(t_p3)) fault_d = 1'b1;
						else begin
							wa_d    = t_p1[AW-1:0];
							wd_d    = cur_q;
							wcnt_d  = 2'd2;
							bn_d    = t_p1[AW-1:0];
							np_d    = arg_q;
							state_d = S_WRITE;
						end
					end
					FN_INC: begin
						if (!inr(t_pa)) fault_d = 1'b1;
						else tn_d = t_pa[AW-1:0];
					end
					FN_JMP: begin
						np_d = arg_q;
					end
					FN_JPC, FN_WRT: begin
						if (t_q == '0) fault_d = 1'b1;
						else begin
							ra_d    = t_q;
							state_d = S_RD1;
						end
					end
					FN_STP: begin
						if (!inr(t_p3) || (t_q == '0)) fault_d = 1'b1;
						else begin
							ra_d    = t_q;
							wa_d    = t_p3[AW-1:0];
							state_d = S_RD1;
						end
					end
					FN_LID, FN_SID: begin
						if (!inr(ea)) fault_d = 1'b1;
						else begin
							ra_d    = ea[AW-1:0];
							state_d = S_RD1;
						end
					end
					FN_LDA: begin
						if (!inr(t_p1)) fault_d = 1'b1;
						else begin
							wa_d    = t_p1[AW-1:0];
							wd_d    = ea[DATA_W-1:0];
							tn_d    = t_p1[AW-1:0];
							state_d = S_WRITE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_RD1: begin
				mem_re  = 1'b1;
				state_d = S_RD1_DATA;
			end

			S_RD1_DATA: begin
				opa_d   = rd_data_q;
				state_d = S_DONE;
				case (func_q)
					FN_OPR: begin
						if (arg_q[3:0] == OPR_RET) begin
							if (!inr(dx)) fault_d = 1'b1;
							else begin
								ra_d    = b_q + AW'(2);
								state_d = S_RD2;
							end
						end else if ((arg_q[3:0] == OPR_NEG) || (arg_q[3:0] == OPR_ODD)) begin
							wa_d    = t_q;
							state_d = S_ALU;
						end else begin
							ra_d    = t_q;
							state_d = S_RD2;
						end
					end
					FN_LOD: begin
						wa_d    = t_p1[AW-1:0];
						wd_d    = rd_data_q;
						tn_d    = t_p1[AW-1:0];
						state_d = S_WRITE;
					end
					FN_STO, FN_STP: begin
						wd_d    = rd_data_q;
						tn_d    = t_q - AW'(1);
						state_d = S_WRITE;
					end
					FN_JPC: begin
						if (rd_data_q == '0) np_d = arg_q;
						tn_d = t_q - AW'(1);
					end
					FN_WRT: begin
						wv_d   = 1'b1;
						wval_d = rd_data_q;
						tn_d   = t_q - AW'(1);
					end
					FN_LID: begin
						if (!inr(dx) || !inr(t_p1)) fault_d = 1'b1;
						else begin
							ra_d    = rd_data_q[AW-1:0];
							state_d = S_RD2;
						end
					end
					FN_SID: begin
						if (!inr(dx) || (t_q == '0)) fault_d = 1'b1;
						else begin
							wa_d    = rd_data_q[AW-1:0];
							ra_d    = t_q;
							state_d = S_RD2;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_RD2: begin
				mem_re  = 1'b1;
				state_d = S_RD2_DATA;
			end

			S_RD2_DATA: begin
				state_d = S_DONE;
				case (func_q)
					FN_OPR: begin
						if (arg_q[3:0] == OPR_RET) begin
							np_d = rd_data_q[PC_W-1:0];
							tn_d = b_q - AW'(1);
							bn_d = opa_q[AW-1:0];
						end else begin
							opb_d   = rd_data_q;
							wa_d    = t_q - AW'(1);
							tn_d    = t_q - AW'(1);
							state_d = S_ALU;
						end
					end
					FN_LID: begin
						wa_d    = t_p1[AW-1:0];
						wd_d    = rd_data_q;
						tn_d    = t_p1[AW-1:0];
						state_d = S_WRITE;
					end
					FN_SID: begin
						wd_d    = rd_data_q;
						tn_d    = t_q - AW'(1);
						state_d = S_WRITE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_ALU: begin
				alu_req.start = 1'b1;
				state_d       = S_ALU_WAIT;
			end

			S_ALU_WAIT: begin
				if (alu_rsp.done) begin
					wd_d    = alu_rsp.value;
					dz_d    = alu_rsp.div_zero;
					state_d = S_WRITE;
				end
			end

			// Stack write; cal stores its three frame cells back to back
			S_WRITE: begin
				mem_we = 1'b1;
				if (wcnt_q == 2'd2) begin
					wa_d   = t_q + AW'(2);
					wd_d   = {{(DATA_W-AW){1'b0}}, b_q};
					wcnt_d = 2'd1;
				end else if (wcnt_q == 2'd1) begin
					wa_d   = t_q + AW'(3);
					wd_d   = {{(DATA_W-PC_W){1'b0}}, pc_q + PC_W'(1)};
					wcnt_d = 2'd0;
				end else begin
					state_d = S_DONE;
				end
			end

			// Commit state and load the result register when it is free
			S_DONE: begin
				if (!rv_q || result_ready) begin
					rv_d              = 1'b1;
					res_d.next_pc     = pc_fin;
					res_d.write_valid = wv_q && !fault_q;
					res_d.write_value = (wv_q && !fault_q) ? wval_q : '0;
					res_d.halted      = (pc_fin == '0);
					res_d.status      = fault_q ? STS_RANGE : (dz_q ? STS_DIV_ZERO : STS_OK);
					pc_d              = pc_fin;
					if (!fault_q) begin
						t_d = tn_q;
						b_d = bn_q;
					end
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/psm_checker.sv =====
module psm_sva_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              instr_valid,
	input logic              instr_ready,
	input psm_pkg::psm_in_t  instr,
	input logic              result_valid,
	input logic              result_ready,
	input psm_pkg::psm_out_t result
);
	import psm_pkg::*;

	// A result that is not taken holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// One instruction at a time: busy right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_ready |=> !instr_ready)
		else $error("instruction taken while busy");

	// Halt flags exactly a zero next pc
	a_halt_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.halted == (result.next_pc == '0)))
		else $error("halt flag does not match next pc");

	// Only a clean wrt emits a value
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (!result.write_valid || (result.status != STS_OK))
		|-> !result.write_valid || (result.status == STS_OK))
		else $error("write value on a faulted instruction");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_valid |-> (result.write_value == '0))
		else $error("write value not zero without write");

endmodule

bind pcode_stack_machine_executor_top psm_sva_checker u_psm_checker (.*);
